FILE: src/wdb_pkg.sv
// ----------------------------------------------------------------------------
// wdb_pkg
// Types and fixed constants shared by the watchdog bank modules.
// ----------------------------------------------------------------------------
package wdb_pkg;

	localparam int SLOT_W        = 4;
	localparam int VAL_W         = 16;
	localparam int TAG_W         = 16;
	localparam int DEFAULT_COUNT = 100;
	localparam int RESULT_CAP    = 16;
	localparam int CAP_W         = $clog2(RESULT_CAP + 1);

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_FEED     = 2'd1,
		OP_QUERY    = 2'd2,
		OP_TICK     = 2'd3
	} wdb_op_t;

	typedef enum logic [2:0] {
		KIND_REGISTERED = 3'd0,
		KIND_FULL       = 3'd1,
		KIND_FED        = 3'd2,
		KIND_STATUS     = 3'd3,
		KIND_TIMEOUT    = 3'd4
	} wdb_kind_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [SLOT_W-1:0] slot;
		logic [VAL_W-1:0]  reload_value;
		logic [VAL_W-1:0]  start_value;
		logic [TAG_W-1:0]  owner_tag;
		logic              alarm_enabled;
	} wdb_in_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot_id;
		logic [TAG_W-1:0]  owner_id_out;
		logic              online;
		logic              last;
	} wdb_out_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // take the input transfer into the item register
		logic rd_in;      // read the slot stores at the incoming slot
		logic do_reg;     // finish a register operation
		logic do_feed;    // finish a feed operation
		logic do_query;   // finish a query operation
		logic tick_init;  // start a tick walk
		logic rd_idx;     // read the slot stores at the walk index
		logic idx_inc;    // advance the walk index
		logic wr_dec;     // write back the decremented count
		logic pend_load;  // hold a new timeout as pending
		logic out_pend;   // move the pending timeout to the output
		logic pend_last;  // that timeout ends the tick
	} wdb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		wdb_op_t op;
		logic    used_zero;
		logic    idx_last;
		logic    cnt_zero;
		logic    alarm;
		logic    cap;
		logic    pend_valid;
		logic    out_free;
	} wdb_stat_t;

endpackage

FILE: src/wdb_ram.sv
// ----------------------------------------------------------------------------
// wdb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module wdb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/wdb_ctrl.sv
// ----------------------------------------------------------------------------
// wdb_ctrl
// Sequencer for the watchdog bank: one operation at a time, tick walks the
// claimed slots in order, reading each in ST_TRD and handling it in ST_TPROC.
// ----------------------------------------------------------------------------
module wdb_ctrl
	import wdb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  wdb_stat_t stat,
	output wdb_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REG,
		ST_FEED,
		ST_QRY,
		ST_TRD,
		ST_TPROC,
		ST_TEND
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		logic advance;
		advance = 1'b0;
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (stat.op)
						OP_REGISTER: state_d = ST_REG;
						OP_FEED: begin
							cmd.rd_in = 1'b1;
							state_d   = ST_FEED;
						end
						OP_QUERY: begin
							cmd.rd_in = 1'b1;
							state_d   = ST_QRY;
						end
						OP_TICK: begin
							cmd.tick_init = 1'b1;
							if (!stat.used_zero) begin
								state_d = ST_TRD;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_REG: begin
				if (stat.out_free) begin
					cmd.do_reg = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FEED: begin
				if (stat.out_free) begin
					cmd.do_feed = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_QRY: begin
				if (stat.out_free) begin
					cmd.do_query = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_TRD: begin
				cmd.rd_idx = 1'b1;
				state_d    = ST_TPROC;
			end
			ST_TPROC: begin
				if (!stat.cnt_zero) begin
					cmd.wr_dec = 1'b1;
					advance    = 1'b1;
				end else if (stat.alarm && !stat.cap) begin
					// a held timeout must leave before the next one is held
					if (!stat.pend_valid || stat.out_free) begin
						cmd.out_pend  = stat.pend_valid;
						cmd.pend_load = 1'b1;
						advance       = 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance) begin
					if (stat.idx_last) begin
						state_d = ST_TEND;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = ST_TRD;
					end
				end
			end
			ST_TEND: begin
				if (!stat.pend_valid) begin
					state_d = ST_IDLE;
				end else if (stat.out_free) begin
					cmd.out_pend  = 1'b1;
					cmd.pend_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: src/wdb_dp.sv
// ----------------------------------------------------------------------------
// wdb_dp
// Datapath: slot stores, claim counter, tick walk index, pending timeout and
// the output register.
// ----------------------------------------------------------------------------
module wdb_dp
	import wdb_pkg::*;
#(
	parameter int MAX_SLOTS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  wdb_in_t   in_data,
	input  logic      out_ready,
	output logic      out_valid,
	output wdb_out_t  out_data,
	input  wdb_cmd_t  cmd,
	output wdb_stat_t stat
);

	localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int UW = $clog2(MAX_SLOTS + 1);
	localparam int IW = (UW > SLOT_W) ? UW : SLOT_W;
	localparam int EW = (COUNT_BITS > VAL_W) ? COUNT_BITS : VAL_W;
	localparam int TW = TAG_W + 1;

	// cut to the count width; zero selects the default count
	function automatic logic [COUNT_BITS-1:0] count_or_default(input logic [VAL_W-1:0] raw);
		logic [EW-1:0]         ext;
		logic [COUNT_BITS-1:0] v;
		ext = EW'(raw);
		v   = ext[COUNT_BITS-1:0];
		return (v == '0) ? COUNT_BITS'(DEFAULT_COUNT) : v;
	endfunction

	wdb_in_t               in_q;
	logic [UW-1:0]         slots_used_q;
	logic [AW-1:0]         idx_q;
	logic [CAP_W-1:0]      n_q;
	logic                  pend_valid_q;
	logic [AW-1:0]         pend_idx_q;
	logic [TAG_W-1:0]      pend_owner_q;
	logic                  out_valid_q;
	wdb_out_t              out_q;

	logic [IW-1:0]         in_slot_w, q_slot_w, used_w, pend_idx_w;
	logic                  full, slot_ok, reg_go, out_free, out_load;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  cnt_we;
	logic [AW-1:0]         cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd, rel_rd;
	logic [TW-1:0]         tag_rd;
	wdb_out_t              out_d;

	assign in_slot_w  = IW'(in_data.slot);
	assign q_slot_w   = IW'(in_q.slot);
	assign used_w     = IW'(slots_used_q);
	assign pend_idx_w = IW'(pend_idx_q);

	assign full     = (slots_used_q == UW'(MAX_SLOTS));
	assign slot_ok  = (q_slot_w < used_w);
	assign reg_go   = cmd.do_reg && !full;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = cmd.do_reg || cmd.do_feed || cmd.do_query || cmd.out_pend;

	// shared read port of the three stores
	assign rd_en   = cmd.rd_in || cmd.rd_idx;
	assign rd_addr = cmd.rd_in ? in_slot_w[AW-1:0] : idx_q;

	// count store write: claim, feed reload or tick decrement
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = cnt_rd - COUNT_BITS'(1);
		if (reg_go) begin
			cnt_we    = 1'b1;
			cnt_waddr = used_w[AW-1:0];
			cnt_wdata = count_or_default(in_q.start_value);
		end else if (cmd.do_feed && slot_ok) begin
			cnt_we    = 1'b1;
			cnt_waddr = q_slot_w[AW-1:0];
			cnt_wdata = rel_rd;
		end else if (cmd.wr_dec) begin
			cnt_we = 1'b1;
		end
	end

	wdb_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SLOTS)) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (cnt_rd)
	);

	wdb_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_SLOTS)) u_reload_ram (
		.clk   (clk),
		.we    (reg_go),
		.waddr (used_w[AW-1:0]),
		.wdata (count_or_default(in_q.reload_value)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rel_rd)
	);

	// alarm enable above the owner tag
	wdb_ram #(.WIDTH(TW), .DEPTH(MAX_SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (reg_go),
		.waddr (used_w[AW-1:0]),
		.wdata ({in_q.alarm_enabled, in_q.owner_tag}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (tag_rd)
	);

	// result selection
	always_comb begin
		out_d = '0;
		if (cmd.do_reg) begin
			out_d.last = 1'b1;
			if (full) begin
				out_d.kind = KIND_FULL;
			end else begin
				out_d.kind    = KIND_REGISTERED;
				out_d.slot_id = used_w[SLOT_W-1:0];
			end
		end else if (cmd.do_feed) begin
			out_d.kind    = KIND_FED;
			out_d.slot_id = in_q.slot;
			out_d.last    = 1'b1;
		end else if (cmd.do_query) begin
			out_d.kind    = KIND_STATUS;
			out_d.slot_id = in_q.slot;
			out_d.online  = slot_ok && (cnt_rd != '0);
			out_d.last    = 1'b1;
		end else begin
			out_d.kind         = KIND_TIMEOUT;
			out_d.slot_id      = pend_idx_w[SLOT_W-1:0];
			out_d.owner_id_out = pend_owner_q;
			out_d.last         = cmd.pend_last;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_used_q <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (reg_go) begin
				slots_used_q <= slots_used_q + UW'(1);
			end
			if (cmd.tick_init) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.tick_init) begin
				n_q <= '0;
			end else if (cmd.pend_load) begin
				n_q <= n_q + CAP_W'(1);
			end
			if (cmd.tick_init) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.out_pend && cmd.pend_last) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.pend_load) begin
			pend_idx_q   <= idx_q;
			pend_owner_q <= tag_rd[TAG_W-1:0];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.op         = wdb_op_t'(in_data.operation);
	assign stat.used_zero  = (slots_used_q == '0);
	assign stat.idx_last   = ((UW'(idx_q) + UW'(1)) == slots_used_q);
	assign stat.cnt_zero   = (cnt_rd == '0);
	assign stat.alarm      = tag_rd[TAG_W];
	assign stat.cap        = (n_q == CAP_W'(RESULT_CAP));
	assign stat.pend_valid = pend_valid_q;
	assign stat.out_free   = out_free;

`ifndef SYNTH
	// never claim past the bank size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slots_used_q <= UW'(MAX_SLOTS))
		else $error("slot count beyond bank size");

	// no more timeouts per tick than the cap
	a_cap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CAP_W'(RESULT_CAP))
		else $error("timeout count beyond cap");

	// a result is loaded only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten");

	// the walk only reads claimed slots
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_idx |-> (UW'(idx_q) < slots_used_q))
		else $error("tick walk beyond claimed slots");

	// a pending timeout was counted
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (n_q != '0))
		else $error("pending timeout without count");
`endif

endmodule

FILE: src/multi_watchdog_bank.sv
// ----------------------------------------------------------------------------
// multi_watchdog_bank
// Bank of software watchdog slots with register, feed, query and tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one operation per
//   transfer: register claims the next free slot, feed reloads a slot's
//   count, query reports whether a count is above zero, tick decrements
//   every claimed nonzero count and reports expired slots with alarms on.
//   Output channel (out_valid/out_ready/out_data) returns results; the
//   final result of an operation carries last. A tick without timeouts
//   returns nothing; a tick returns at most 16 timeouts, lowest slots first.
//   Register, feed and query finish before the next operation is taken;
//   the result is loaded into the output register once it is free (feed
//   and query read the slot stores at the transfer edge). A tick walks
//   the claimed slots in order and then closes, or stays idle with an
//   empty bank; the walk reads each slot's count, reload and tag RAMs
//   once through their shared read port.
//   A new operation is taken while the previous result still waits in the
//   output register; if the receiver stalls, the block holds in place
//   until the output register frees. Reset empties the bank and the output
//   register; slot stores need no clearing.
// ----------------------------------------------------------------------------
module multi_watchdog_bank
	import wdb_pkg::*;
#(
	parameter int MAX_SLOTS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  wdb_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output wdb_out_t out_data
);

	wdb_cmd_t  cmd;
	wdb_stat_t stat;

	wdb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	wdb_dp #(
		.MAX_SLOTS  (MAX_SLOTS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the watchdog slot bank. A directed opening covers
// unclaimed slots, default counts, alarm on/off and expiry timing. A random
// phase follows with well-formed traffic, a bank-full phase, bursty idling
// on both channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top
	import wdb_pkg::*;
();

	localparam int NUM_SLOTS    = 16;
	localparam int RANDOM_OPS   = 290;
	localparam int QUIET_TAIL   = 40;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	// Predicts the bank's answers and checks each output transfer in order
	class watchdog_bank_sb;
		int             claimed;
		logic [15:0]    count_q [NUM_SLOTS];
		logic [15:0]    reload_q [NUM_SLOTS];
		logic [15:0]    owner_q [NUM_SLOTS];
		logic           alarm_q [NUM_SLOTS];
		wdb_out_t       due_results [$];
		int             errors;
		int             checked;

		function new();
			claimed = 0;
			errors  = 0;
			checked = 0;
		endfunction

		function automatic logic [15:0] count_or_default(input logic [15:0] v);
			return (v == '0) ? 16'(DEFAULT_COUNT) : v;
		endfunction

		function automatic void add_result(input wdb_kind_t kind, input int slot,
				input logic [15:0] owner, input logic on, input logic fin);
			wdb_out_t r;
			r.kind         = kind;
			r.slot_id      = slot[SLOT_W-1:0];
			r.owner_id_out = owner;
			r.online       = on;
			r.last         = fin;
			due_results.push_back(r);
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		// Update the slot state for one accepted operation and queue its results
		function automatic void take_operation(input wdb_in_t it);
			int n;
			int first;
			n = 0;
			case (wdb_op_t'(it.operation))
				OP_REGISTER: begin
					if (claimed >= NUM_SLOTS) begin
						add_result(KIND_FULL, 0, '0, 1'b0, 1'b1);
					end else begin
						reload_q[claimed] = count_or_default(it.reload_value);
						count_q[claimed]  = count_or_default(it.start_value);
						owner_q[claimed]  = it.owner_tag;
						alarm_q[claimed]  = it.alarm_enabled;
						add_result(KIND_REGISTERED, claimed, '0, 1'b0, 1'b1);
						claimed++;
					end
				end
				OP_FEED: begin
					if (it.slot < claimed)
						count_q[it.slot] = reload_q[it.slot];
					add_result(KIND_FED, it.slot, '0, 1'b0, 1'b1);
				end
				OP_QUERY: begin
					add_result(KIND_STATUS, it.slot, '0,
						(it.slot < claimed) && (count_q[it.slot] != '0), 1'b1);
				end
				default: begin
					// tick: expired slots report before being left at zero
					first = due_results.size();
					for (int i = 0; i < claimed; i++) begin
						if (count_q[i] != '0) begin
							count_q[i] = count_q[i] - 16'd1;
						end else if (alarm_q[i] && n < RESULT_CAP) begin
							add_result(KIND_TIMEOUT, i, owner_q[i], 1'b0, 1'b0);
							n++;
						end
					end
					if (n > 0)
						due_results[first + n - 1].last = 1'b1;
				end
			endcase
		endfunction

		task check_result(input wdb_out_t got);
			wdb_out_t want;
			checked++;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected result kind %0d slot %0d",
					got.kind, got.slot_id));
			end else begin
				want = due_results.pop_front();
				if (got.kind !== want.kind)
					report($sformatf("kind %0d, want %0d", got.kind, want.kind));
				if (got.slot_id !== want.slot_id)
					report($sformatf("slot_id %0d, want %0d", got.slot_id, want.slot_id));
				if (got.owner_id_out !== want.owner_id_out)
					report($sformatf("owner_id_out %h, want %h",
						got.owner_id_out, want.owner_id_out));
				if (got.online !== want.online)
					report($sformatf("online %b, want %b", got.online, want.online));
				if (got.last !== want.last)
					report($sformatf("last %b, want %b", got.last, want.last));
			end
		endtask

		function int outstanding();
			return due_results.size();
		endfunction
	endclass

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	wdb_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	wdb_out_t out_data;

	watchdog_bank_sb sb;
	bit              quiet = 1'b0;

	multi_watchdog_bank DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sample both channels at the edge where a transfer completes
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.take_operation(in_data);
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	function automatic wdb_in_t make_op(input wdb_op_t op, input logic [3:0] slot,
			input logic [15:0] rl, input logic [15:0] st, input logic [15:0] tag,
			input logic al);
		wdb_in_t it;
		it.operation     = op;
		it.slot          = slot;
		it.reload_value  = rl;
		it.start_value   = st;
		it.owner_tag     = tag;
		it.alarm_enabled = al;
		return it;
	endfunction

	// Mostly short counts so slots expire; some zero (default) and full range
	function automatic logic [15:0] pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 16'($urandom);
		return 16'($urandom_range(1, 6));
	endfunction

	function automatic wdb_in_t random_op(input int used);
		int          r;
		wdb_op_t     op;
		logic [3:0]  slot;
		r = $urandom_range(0, 99);
		if (r < ((used < NUM_SLOTS) ? 20 : 3))
			op = OP_REGISTER;
		else if (r < 45)
			op = OP_FEED;
		else if (r < 62)
			op = OP_QUERY;
		else
			op = OP_TICK;
		if (used > 0 && $urandom_range(0, 4) != 0)
			slot = 4'($urandom_range(0, used - 1));
		else
			slot = 4'($urandom);
		return make_op(op, slot, pick_count(), pick_count(), 16'($urandom),
			$urandom_range(0, 6) != 0);
	endfunction

	// Call at a rising edge; returns at the edge where the transfer happens
	task automatic send_op(input wdb_in_t it);
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Receiver: random stall bursts, one long hold-off, none in the tail
	initial begin : sink
		bit hold_done;
		hold_done = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (!hold_done && sb.checked >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		wdb_in_t directed [$];
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// unclaimed slots and an empty tick
		directed.push_back(make_op(OP_QUERY, 4'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
		directed.push_back(make_op(OP_FEED, 4'd15, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0));
		// zero values default to 100; full-scale tags; alarm off on slot 2
		directed.push_back(make_op(OP_REGISTER, 4'd0, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
		directed.push_back(make_op(OP_REGISTER, 4'd0, 16'h0001, 16'h0001, 16'h0000, 1'b1));
		directed.push_back(make_op(OP_REGISTER, 4'd0, 16'hFFFF, 16'h0001, 16'hA5A5, 1'b0));
		directed.push_back(make_op(OP_REGISTER, 4'd0, 16'h0002, 16'h0002, 16'h1234, 1'b1));
		// expiry shows from the tick after reaching zero, repeats until fed
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_QUERY, 4'd1, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_QUERY, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_QUERY, 4'd2, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_FEED, 4'd1, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_QUERY, 4'd1, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_FEED, 4'd2, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_QUERY, 4'd9, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_FEED, 4'd3, 16'h0, 16'h0, 16'h0, 1'b0));
		directed.push_back(make_op(OP_TICK, 4'd0, 16'h0, 16'h0, 16'h0, 1'b0));
		foreach (directed[i]) begin
			send_op(directed[i]);
			if ($urandom_range(0, 3) == 0)
				idle_input($urandom_range(1, 11));
		end

		// random traffic; the tail runs with no idling on either side
		for (int i = 0; i < RANDOM_OPS; i++) begin
			if (i >= RANDOM_OPS - QUIET_TAIL)
				quiet = 1'b1;
			send_op(random_op(sb.claimed));
			if (!quiet && $urandom_range(0, 3) == 0)
				idle_input($urandom_range(1, 11));
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Hard stop well beyond the slowest legal run
	initial begin : watchdog_limit
		#10_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: multi_watchdog_bank.f
src/wdb_pkg.sv
src/wdb_ram.sv
src/wdb_ctrl.sv
src/wdb_dp.sv
src/multi_watchdog_bank.sv
verif/tb_top.sv
